### hdl/bzrf_pkg.sv
// Shared definitions for the bitmap zero-run finder: sizes, state and select codes,
// and the controller/datapath command and status bundles.
// No dependencies.
package bzrf_pkg;

	localparam int MAP_WORDS = 64;
	localparam int WORD_W    = 64;
	localparam int WADDR_W   = $clog2(MAP_WORDS);
	localparam int OFF_W     = $clog2(WORD_W);
	localparam int BIT_W     = 12;
	localparam int POS_W     = 13;
	localparam int END_W     = 14;
	localparam int MASK_W    = 12;

	localparam logic [POS_W-1:0] MAP_CAP = POS_W'(MAP_WORDS * WORD_W);

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_ALIGN,
		ST_CHECK,
		ST_SCAN
	} state_t;

	typedef enum logic [2:0] {
		PTR_HOLD,
		PTR_START,
		PTR_NEXT_WORD,
		PTR_RESTART,
		PTR_IDX
	} ptr_sel_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_ZERO,
		POS_SIZE
	} pos_sel_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_WRITE,
		RES_FAIL,
		RES_OK
	} res_sel_t;

	typedef struct packed {
		logic     load_req;
		logic     wr_en;
		ptr_sel_t ptr_sel;
		pos_sel_t pos_sel;
		logic     idx_ld;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic start_past;
		logic zero_done;
		logic set_hit;
		logic restart_past;
		logic scan_done;
		logic end_over;
		logic run_empty;
	} sts_t;

	// Lowest set bit of a word: {found, offset}.
	function automatic logic [OFF_W:0] lowest_one(input logic [WORD_W-1:0] v);
		logic [OFF_W:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, OFF_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

### hdl/bitmap_zero_run_finder_unit.sv
// Top level of the bitmap zero-run finder.
// Depends on bzrf_pkg, bzrf_ctrl and bzrf_dp.
//
// Usage: requests arrive as beats on the req channel (req_valid/req_ready).
// A write beat (req_type 0) replaces bitmap word word_addr with word_data; a
// search beat (req_type 1) looks for run_length zero bits starting at or after
// start_bit, with the start rounded up by round_mask. Every request gives one
// beat on the res channel (res_valid/res_ready): position and fits.
// The map size used by searches is set through cfg_wr_en/cfg_wr_data, which
// takes effect at once and must only be written while the block is idle.
// A write answers in the cycle after its beat is taken. A search reads one
// 64-bit bitmap word per cycle through the single memory read port while it
// scans; every rounding pass (one at the start and one after every set bit
// that breaks a candidate run) goes through the ALIGN and CHECK states. Each
// restart searches for the next zero bit unless it lies past the map size,
// rounds the candidate up and then scans the words of the new run.
// Only one request is worked on at a time. A result waits in the output
// register while res_ready is low; a new request is taken in the same cycle
// that the waiting result is taken, but not before.
// Reset clears the whole bitmap to zero and sets the map size to 4096 bits.
module bitmap_zero_run_finder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bzrf_pkg::POS_W-1:0]    cfg_wr_data,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_type,
	input  logic [bzrf_pkg::WADDR_W-1:0]  word_addr,
	input  logic [bzrf_pkg::WORD_W-1:0]   word_data,
	input  logic [bzrf_pkg::BIT_W-1:0]    start_bit,
	input  logic [bzrf_pkg::POS_W-1:0]    run_length,
	input  logic [bzrf_pkg::MASK_W-1:0]   round_mask,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [bzrf_pkg::END_W-1:0]    position,
	output logic                          fits
);
	import bzrf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences the search; all bit positions live in the datapath.
	bzrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bzrf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.word_addr   (word_addr),
		.word_data   (word_data),
		.start_bit   (start_bit),
		.run_length  (run_length),
		.round_mask  (round_mask),
		.cmd         (cmd),
		.sts         (sts),
		.position    (position),
		.fits        (fits)
	);

endmodule

### hdl/bzrf_ctrl.sv
// Sequencing state machine of the bitmap zero-run finder.
// Depends on bzrf_pkg; drives the datapath through cmd_t and reads sts_t back.
module bzrf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  logic          req_type,
	output logic          res_valid,
	input  logic          res_ready,
	input  bzrf_pkg::sts_t sts,
	output bzrf_pkg::cmd_t cmd
);
	import bzrf_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_sel != RES_NONE) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.load_req = 1'b0;
		cmd.wr_en    = 1'b0;
		cmd.ptr_sel  = PTR_HOLD;
		cmd.pos_sel  = POS_HOLD;
		cmd.idx_ld   = 1'b0;
		cmd.res_sel  = RES_NONE;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !res_valid_q || res_ready;
				if (req_valid && req_ready) begin
					if (req_type == REQ_WRITE) begin
						cmd.wr_en   = 1'b1;
						cmd.res_sel = RES_WRITE;
					end else begin
						cmd.load_req = 1'b1;
						cmd.ptr_sel  = PTR_START;
						if (sts.start_past) begin
							cmd.pos_sel = POS_SIZE;
							state_d     = ST_ALIGN;
						end else begin
							state_d = ST_ZERO;
						end
					end
				end
			end
			ST_ZERO: begin
				if (sts.zero_done) begin
					cmd.pos_sel = POS_ZERO;
					state_d     = ST_ALIGN;
				end else begin
					cmd.ptr_sel = PTR_NEXT_WORD;
				end
			end
			ST_ALIGN: begin
				cmd.idx_ld = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.end_over) begin
					cmd.res_sel = RES_FAIL;
					state_d     = ST_IDLE;
				end else if (sts.run_empty) begin
					cmd.res_sel = RES_OK;
					state_d     = ST_IDLE;
				end else begin
					cmd.ptr_sel = PTR_IDX;
					state_d     = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.set_hit) begin
					cmd.ptr_sel = PTR_RESTART;
					if (sts.restart_past) begin
						cmd.pos_sel = POS_SIZE;
						state_d     = ST_ALIGN;
					end else begin
						state_d = ST_ZERO;
					end
				end else if (sts.scan_done) begin
					cmd.res_sel = RES_OK;
					state_d     = ST_IDLE;
				end else begin
					cmd.ptr_sel = PTR_NEXT_WORD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res_valid = res_valid_q;

endmodule

### hdl/bzrf_dp.sv
// Datapath of the bitmap zero-run finder: bitmap memory, search pointers,
// word examination logic, map size register and result register.
// Depends on bzrf_pkg; controlled by bzrf_ctrl.
module bzrf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [bzrf_pkg::POS_W-1:0]        cfg_wr_data,
	input  logic [bzrf_pkg::WADDR_W-1:0]      word_addr,
	input  logic [bzrf_pkg::WORD_W-1:0]       word_data,
	input  logic [bzrf_pkg::BIT_W-1:0]        start_bit,
	input  logic [bzrf_pkg::POS_W-1:0]        run_length,
	input  logic [bzrf_pkg::MASK_W-1:0]       round_mask,
	input  bzrf_pkg::cmd_t                    cmd,
	output bzrf_pkg::sts_t                    sts,
	output logic [bzrf_pkg::END_W-1:0]        position,
	output logic                              fits
);
	import bzrf_pkg::*;

	logic [WORD_W-1:0]    mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] wvalid_q;
	logic [WORD_W-1:0]    rd_data_q;
	logic                 rd_vld_q;

	logic [POS_W-1:0]  size_q;
	logic [POS_W-1:0]  ptr_q;
	logic [POS_W-1:0]  ptr_d;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  idx_q;
	logic [END_W-1:0]  end_q;
	logic [POS_W-1:0]  nr_q;
	logic [MASK_W-1:0] mask_q;
	logic [END_W-1:0]  position_q;
	logic              fits_q;

	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  lo_mask;
	logic [WORD_W-1:0]  hi_mask;
	logic [OFF_W:0]     zero_enc;
	logic [OFF_W:0]     set_enc;
	logic [POS_W-1:0]   next_base;
	logic [POS_W-1:0]   zero_pos;
	logic [POS_W-1:0]   zpos;
	logic [POS_W-1:0]   restart_pos;
	logic [POS_W-1:0]   aligned;
	logic [END_W-1:0]   end_sum;
	logic [WADDR_W-1:0] cur_word;

	// Map size register, clamped to the storage on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= MAP_CAP;
		end else if (cfg_wr_en) begin
			size_q <= (cfg_wr_data > MAP_CAP) ? MAP_CAP : cfg_wr_data;
		end
	end

	// Bitmap storage. Words never written read as zero through their valid bit.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[word_addr] <= word_data;
		end
		rd_data_q <= mem[ptr_d[BIT_W-1:OFF_W]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				wvalid_q[word_addr] <= 1'b1;
			end
			rd_vld_q <= wvalid_q[ptr_d[BIT_W-1:OFF_W]];
		end
	end

	assign word     = rd_vld_q ? rd_data_q : '0;
	assign cur_word = ptr_q[BIT_W-1:OFF_W];

	// Examination of the word under the pointer.
	assign lo_mask  = {WORD_W{1'b1}} << ptr_q[OFF_W-1:0];
	assign hi_mask  = (end_q[END_W-1:OFF_W] == (END_W-OFF_W)'(cur_word))
		? ~({WORD_W{1'b1}} << end_q[OFF_W-1:0]) : {WORD_W{1'b1}};
	assign zero_enc = lowest_one(~word & lo_mask);
	assign set_enc  = lowest_one(word & lo_mask & hi_mask);

	assign next_base   = {(POS_W-OFF_W)'(cur_word) + (POS_W-OFF_W)'(1), {OFF_W{1'b0}}};
	assign zero_pos    = {1'b0, cur_word, zero_enc[OFF_W-1:0]};
	assign zpos        = (zero_enc[OFF_W] && (zero_pos < size_q)) ? zero_pos : size_q;
	assign restart_pos = {1'b0, cur_word, set_enc[OFF_W-1:0]} + POS_W'(1);

	assign aligned = (pos_q + {1'b0, mask_q}) & ~{1'b0, mask_q};
	assign end_sum = {1'b0, idx_q} + {1'b0, nr_q};

	assign sts.start_past   = {1'b0, start_bit} >= size_q;
	assign sts.zero_done    = zero_enc[OFF_W] || (next_base >= size_q);
	assign sts.set_hit      = set_enc[OFF_W];
	assign sts.restart_past = restart_pos >= size_q;
	assign sts.scan_done    = {1'b0, next_base} >= end_q;
	assign sts.end_over     = end_sum > {1'b0, size_q};
	assign sts.run_empty    = (nr_q == '0);

	always_comb begin
		unique case (cmd.ptr_sel)
			PTR_START:     ptr_d = {1'b0, start_bit};
			PTR_NEXT_WORD: ptr_d = next_base;
			PTR_RESTART:   ptr_d = restart_pos;
			PTR_IDX:       ptr_d = idx_q;
			default:       ptr_d = ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		end_q <= end_sum;
		if (cmd.load_req) begin
			nr_q   <= run_length;
			mask_q <= round_mask;
		end
		unique case (cmd.pos_sel)
			POS_ZERO: pos_q <= zpos;
			POS_SIZE: pos_q <= size_q;
			default:  pos_q <= pos_q;
		endcase
		if (cmd.idx_ld) begin
			idx_q <= aligned;
		end
		unique case (cmd.res_sel)
			RES_WRITE: begin
				position_q <= '0;
				fits_q     <= 1'b0;
			end
			RES_FAIL: begin
				position_q <= end_sum;
				fits_q     <= 1'b0;
			end
			RES_OK: begin
				position_q <= {1'b0, idx_q};
				fits_q     <= 1'b1;
			end
			default: begin
				position_q <= position_q;
				fits_q     <= fits_q;
			end
		endcase
	end

	assign position = position_q;
	assign fits     = fits_q;

endmodule

### sim/bzrf_checker.sv
// Scoreboard for the bitmap zero-run finder: keeps its own bitmap and map size,
// predicts the answer to every request beat and compares it with each result beat.
// Depends on bzrf_pkg.
module bzrf_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bzrf_pkg::POS_W-1:0]    cfg_wr_data,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic                          req_type,
	input  logic [bzrf_pkg::WADDR_W-1:0]  word_addr,
	input  logic [bzrf_pkg::WORD_W-1:0]   word_data,
	input  logic [bzrf_pkg::BIT_W-1:0]    start_bit,
	input  logic [bzrf_pkg::POS_W-1:0]    run_length,
	input  logic [bzrf_pkg::MASK_W-1:0]   round_mask,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [bzrf_pkg::END_W-1:0]    position,
	input  logic                          fits,
	output int unsigned                   mismatch_count,
	output int unsigned                   pending_answers
);
	import bzrf_pkg::*;

	localparam int MAP_BITS_RESET = 4096;
	localparam int STORE_BITS     = MAP_WORDS * WORD_W;

	typedef struct packed {
		logic [END_W-1:0] pos;
		logic             fit;
	} answer_t;

	logic [WORD_W-1:0] occupancy [MAP_WORDS];
	logic [POS_W-1:0]  map_bits;
	answer_t           answers [$];
	answer_t           want;
	int unsigned       errors;

	function automatic logic occupied(input int unsigned b);
		return occupancy[b / WORD_W][b % WORD_W];
	endfunction

	// Aligned first-fit search; every set bit inside a candidate run moves the
	// search to the bit just past it.
	function automatic answer_t find_zero_run(input int unsigned from_bit,
			input int unsigned want_len, input int unsigned mask);
		int unsigned size;
		int unsigned scan;
		int unsigned cand;
		int unsigned stop;
		int unsigned probe;
		answer_t     ans;
		size = (map_bits < STORE_BITS) ? map_bits : STORE_BITS;
		while (1) begin
			scan = from_bit;
			while (scan < size && occupied(scan)) begin
				scan++;
			end
			if (scan > size) begin
				scan = size;
			end
			cand = (scan + mask) & ~mask;
			stop = cand + want_len;
			if (stop > size) begin
				ans.pos = END_W'(stop);
				ans.fit = 1'b0;
				return ans;
			end
			probe = cand;
			while (probe < stop && !occupied(probe)) begin
				probe++;
			end
			if (probe < stop) begin
				from_bit = probe + 1;
			end else begin
				ans.pos = END_W'(cand);
				ans.fit = 1'b1;
				return ans;
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (occupancy[w]) begin
				occupancy[w] = '0;
			end
			map_bits = POS_W'(MAP_BITS_RESET);
			answers.delete();
			errors = 0;
			mismatch_count <= 0;
			pending_answers <= 0;
		end else begin
			if (cfg_wr_en) begin
				map_bits = cfg_wr_data;
			end
			if (res_valid && res_ready) begin
				if (answers.size() == 0) begin
					errors++;
					$display("%0t unexpected result beat: position %0d fits %0d",
						$time, position, fits);
				end else begin
					want = answers.pop_front();
					if (position !== want.pos) begin
						errors++;
						$display("%0t position mismatch: expected %0d, actual %0d",
							$time, want.pos, position);
					end
					if (fits !== want.fit) begin
						errors++;
						$display("%0t fits mismatch: expected %0d, actual %0d",
							$time, want.fit, fits);
					end
				end
			end
			if (req_valid && req_ready) begin
				if (req_type == REQ_WRITE) begin
					occupancy[word_addr] = word_data;
					answers.push_back('{pos: '0, fit: 1'b0});
				end else begin
					answers.push_back(find_zero_run(start_bit, run_length, round_mask));
				end
			end
			mismatch_count <= errors;
			pending_answers <= answers.size();
		end
	end

endmodule

### sim/bitmap_zero_run_finder_unit_tb.sv
// Testbench top for the bitmap zero-run finder: drives request beats, map size
// writes and result back-pressure, and reports the verdict of the checker.
// Depends on bzrf_pkg, bzrf_checker and bitmap_zero_run_finder_unit.
module bitmap_zero_run_finder_unit_tb;
	import bzrf_pkg::*;

	// Every input of the block starts at a known value.
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [POS_W-1:0]   cfg_wr_data = '0;
	logic               req_valid   = 1'b0;
	logic               req_ready;
	logic               req_type    = REQ_WRITE;
	logic [WADDR_W-1:0] word_addr   = '0;
	logic [WORD_W-1:0]  word_data   = '0;
	logic [BIT_W-1:0]   start_bit   = '0;
	logic [POS_W-1:0]   run_length  = '0;
	logic [MASK_W-1:0]  round_mask  = '0;
	logic               res_valid;
	logic               res_ready   = 1'b0;
	logic [END_W-1:0]   position;
	logic               fits;

	int unsigned mismatch_count;
	int unsigned pending_answers;

	// Idle rates in percent for the sender and the receiver. The sender's rate
	// lives in the stimulus process; the receiver's is handed over with
	// nonblocking writes since another process reads it.
	int tx_idle_pct = 28;
	int rx_idle_pct = 28;

	// One long receiver hold-off, requested by the stimulus and counted down by
	// the receiver process itself.
	logic long_hold_go    = 1'b0;
	logic long_hold_taken = 1'b0;
	int   hold_left       = 0;

	// Map size the block currently uses, so that random starts can favor the
	// part of the map that searches actually examine.
	int cur_map_bits = 4096;

	// Map sizes of the random phases: the register extremes, a size of one, the
	// full storage and a few in between.
	int phase_sizes [8] = '{4096, 1, 0, 8191, 97, 640, 2049, 4096};

	bitmap_zero_run_finder_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.word_addr   (word_addr),
		.word_data   (word_data),
		.start_bit   (start_bit),
		.run_length  (run_length),
		.round_mask  (round_mask),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.position    (position),
		.fits        (fits)
	);

	bzrf_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.req_type        (req_type),
		.word_addr       (word_addr),
		.word_data       (word_data),
		.start_bit       (start_bit),
		.run_length      (run_length),
		.round_mask      (round_mask),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.position        (position),
		.fits            (fits),
		.mismatch_count  (mismatch_count),
		.pending_answers (pending_answers)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver side. Outside the long hold-off, ready drops at random; the hold-off
	// keeps it low long enough for a result to sit in the output register and
	// the block to refuse further request beats.
	always @(posedge clk) begin
		if (long_hold_go && !long_hold_taken) begin
			long_hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			res_ready <= 1'b0;
			hold_left--;
		end else begin
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offers one request beat and returns at the edge where it is taken. Valid
	// stays high into the next call unless that call decides to idle first, so
	// back-to-back beats never lower and raise valid in the same step.
	task automatic send_req(input logic kind, input logic [WADDR_W-1:0] addr,
			input logic [WORD_W-1:0] data, input logic [BIT_W-1:0] sb,
			input logic [POS_W-1:0] len, input logic [MASK_W-1:0] mask);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= kind;
		word_addr  <= addr;
		word_data  <= data;
		start_bit  <= sb;
		run_length <= len;
		round_mask <= mask;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
	endtask

	task automatic write_word(input logic [WADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
		send_req(REQ_WRITE, addr, data, '0, '0, '0);
	endtask

	task automatic search_run(input logic [BIT_W-1:0] sb, input logic [POS_W-1:0] len,
			input logic [MASK_W-1:0] mask);
		send_req(REQ_SEARCH, '0, '0, sb, len, mask);
	endtask

	// Stops offering beats and waits until every predicted answer has come back.
	// The first edge lets the checker count the beat taken at the current edge.
	task automatic drain_answers();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_answers != 0) begin
			@(posedge clk);
		end
	endtask

	// The map size register may only change while the block is idle.
	task automatic set_map_size(input int bits);
		drain_answers();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= POS_W'(bits);
		cur_map_bits = bits;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random beat. Writes build maps with empty, full, sparse, dense and banded
	// words so that searches see long free runs as well as many restarts.
	// Fields that a beat does not use still carry random values.
	task automatic send_random_item();
		logic               kind;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
		logic [BIT_W-1:0]   sb;
		logic [POS_W-1:0]   len;
		logic [MASK_W-1:0]  mask;
		int                 pick;
		int                 span;
		kind = ($urandom_range(99) < 35) ? REQ_WRITE : REQ_SEARCH;
		if ($urandom_range(1) == 1 && cur_map_bits < 4096) begin
			addr = WADDR_W'($urandom_range(cur_map_bits / WORD_W));
		end else begin
			addr = WADDR_W'($urandom);
		end
		pick = $urandom_range(5);
		unique case (pick)
			0: begin
				data = '0;
			end
			1: begin
				data = '1;
			end
			2: begin
				data = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
			end
			3: begin
				data = {$urandom, $urandom};
			end
			4: begin
				data = ~((64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63)));
			end
			default: begin
				data = ((64'd1 << $urandom_range(32)) - 64'd1) << $urandom_range(31);
			end
		endcase
		span = (cur_map_bits < 4096) ? cur_map_bits + 8 : 4095;
		if (span > 4095) begin
			span = 4095;
		end
		sb = ($urandom_range(1) == 1) ? BIT_W'($urandom_range(span)) : BIT_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 50) begin
			len = POS_W'($urandom_range(16));
		end else if (pick < 80) begin
			len = POS_W'($urandom_range(200, 17));
		end else if (pick < 95) begin
			len = POS_W'($urandom_range(4096, 201));
		end else begin
			len = '0;
		end
		pick = $urandom_range(99);
		if (pick < 70) begin
			mask = MASK_W'((1 << $urandom_range(12)) - 1);
		end else if (pick < 85) begin
			mask = '0;
		end else begin
			// Masks that are not a power of two minus one are rounded as given.
			mask = MASK_W'($urandom);
		end
		send_req(kind, addr, data, sb, len, mask);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the cleared map at the reset map size.
		search_run(12'd0, 13'd1, 12'd0);
		search_run(12'd4095, 13'd0, 12'd0);
		search_run(12'd4095, 13'd4096, 12'hFFF);
		search_run(12'd0, 13'd4096, 12'd0);
		write_word(6'd0, '1);
		write_word(6'd63, '1);
		write_word(6'd5, 64'h8000_0000_0000_0001);
		write_word(6'd10, 64'hAAAA_AAAA_AAAA_AAAA);
		write_word(6'd11, 64'h5555_5555_5555_5555);
		search_run(12'd0, 13'd1, 12'd0);
		search_run(12'd0, 13'd300, 12'd0);
		search_run(12'd1, 13'd16, 12'hFFF);
		search_run(12'd3, 13'd40, 12'h5A5);
		// A start inside the full last word finds its first zero at the size
		// itself; a zero length then still fits.
		search_run(12'd4095, 13'd0, 12'd0);
		search_run(12'd4000, 13'd1, 12'd0);
		search_run(12'd640, 13'd2, 12'd0);
		search_run(12'd700, 13'd3, 12'd1);
		write_word(6'd63, '0);
		// With a map size of zero no bit is examined at all.
		set_map_size(0);
		search_run(12'd0, 13'd0, 12'd0);
		search_run(12'd17, 13'd5, 12'd7);
		// A start past the map size is treated as a start at the size.
		set_map_size(100);
		search_run(12'd200, 13'd0, 12'd3);
		search_run(12'd99, 13'd1, 12'd0);
		// A map size above the storage is clipped to the storage.
		set_map_size(8191);
		search_run(12'd4090, 13'd6, 12'd0);

		// Random phases, one per map size.
		for (int p = 0; p < 8; p++) begin
			set_map_size(phase_sizes[p]);
			if (p == 4) begin
				long_hold_go <= 1'b1;
			end
			if (p == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end
			for (int n = 0; n < 60; n++) begin
				send_random_item();
				// In one phase the sender also pauses now and then until every
				// outstanding result has been taken.
				if (p == 5 && n % 20 == 19) begin
					drain_answers();
				end
			end
			if (p == 6) begin
				tx_idle_pct = 28;
				rx_idle_pct <= 28;
			end
		end

		drain_answers();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && pending_answers == 0) begin
			$display("bitmap_zero_run_finder_unit_tb: clean");
		end else begin
			$display("bitmap_zero_run_finder_unit_tb: errors");
		end
		$finish;
	end

	// Watchdog for a block that stops answering.
	initial begin
		#200000000;
		$display("bitmap_zero_run_finder_unit_tb: errors");
		$finish;
	end

endmodule
